@@ rtl/encoder_angle_velocity_tracker_core_macros.svh @@
// assertion macros for the encoder tracker
// no dependencies
`ifndef ENCODER_ANGLE_VELOCITY_TRACKER_CORE_MACROS_SVH
`define ENCODER_ANGLE_VELOCITY_TRACKER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define EVAV_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define EVAV_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define EVAV_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define EVAV_ASSERT_NXT(lbl, clk, rst_n, a, c)
`endif
`endif

@@ rtl/evav_pkg.sv @@
// shared types, constants and functions of the encoder tracker
// no dependencies
package evav_pkg;

  localparam int MotorCount = 3;
  localparam int AngleBits  = 14;
  localparam int AngHalf    = 1 << (AngleBits - 1);
  localparam int AngFull    = 1 << AngleBits;
  localparam int MotorIdxW  = 2;

  // 1e6 * 2pi in q24
  localparam logic [47:0] VelK  = 48'd105414357000000;
  localparam logic [23:0] VelKLo = VelK[23:0];
  localparam logic [23:0] VelKHi = VelK[47:24];
  localparam logic [22:0] VelLim = 23'd6553600;

  localparam int DivW  = 48;
  localparam int DvsW  = 25;

  localparam logic [2:0] CFG_DIR  = 3'd0;
  localparam logic [2:0] CFG_ZO0  = 3'd1;
  localparam logic [2:0] CFG_ZO1  = 3'd2;
  localparam logic [2:0] CFG_ZO2  = 3'd3;
  localparam logic [2:0] CFG_PP   = 3'd4;
  localparam logic [2:0] CFG_TF   = 3'd5;
  localparam logic [2:0] CFG_WIN  = 3'd6;
  localparam logic [2:0] CFG_TO   = 3'd7;

  typedef struct packed {
    logic                        seeded;
    logic [AngleBits-1:0]        last_angle;
    logic signed [31:0]          turn_count;
    logic [AngleBits-1:0]        ref_angle;
    logic [31:0]                 ref_time;
    logic signed [23:0]          velocity;
    logic                        primed;
  } st_t;

  function automatic logic signed [AngleBits:0] wrap_diff(
    logic [AngleBits-1:0] now_a, logic [AngleBits-1:0] prev_a);
    logic signed [AngleBits:0] d;
    d = $signed({1'b0, now_a}) - $signed({1'b0, prev_a});
    if (d > (AngleBits+1)'(AngHalf)) begin
      d = d - (AngleBits+1)'(AngFull);
    end else if (d < -$signed((AngleBits+1)'(AngHalf))) begin
      d = d + (AngleBits+1)'(AngFull);
    end
    return d;
  endfunction

  function automatic logic [AngleBits-1:0] elec_angle(
    logic [AngleBits-1:0] ang, logic [5:0] pp, logic rev, logic [AngleBits-1:0] zo);
    logic [AngleBits+5:0]  prod;
    logic [AngleBits-1:0]  mech;
    prod = ang * pp;
    mech = prod[AngleBits-1:0];
    if (rev) begin
      mech = -mech;
    end
    return mech - zo;
  endfunction

endpackage

@@ rtl/evav_if.sv @@
// valid/ready channel interfaces for readings and results
// depends on evav_pkg
interface evav_in_if import evav_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            motor_index;
  logic [AngleBits-1:0]  raw_angle;
  logic [31:0]           sample_time_us;
  logic                  read_ok;
  modport source (output valid, motor_index, raw_angle, sample_time_us, read_ok,
                  input ready);
  modport sink (input valid, motor_index, raw_angle, sample_time_us, read_ok,
                output ready);
endinterface

interface evav_out_if import evav_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [31:0]    multi_turn_count;
  logic signed [23:0]    filtered_velocity;
  logic [AngleBits-1:0]  elec_phase;
  logic                  velocity_updated;
  modport source (output valid, multi_turn_count, filtered_velocity, elec_phase,
                  velocity_updated, input ready);
  modport sink (input valid, multi_turn_count, filtered_velocity, elec_phase,
                velocity_updated, output ready);
endinterface

@@ rtl/evav_div.sv @@
// restoring divider, one quotient bit per cycle
// depends on evav_pkg
module evav_div import evav_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DivW-1:0]  dividend,
  input  logic [DvsW-1:0]  divisor,
  output logic             busy,
  output logic             done,
  output logic [DivW-1:0]  quotient
);

  logic [DivW-1:0]          quo_r, quo_nxt;
  logic [DvsW-1:0]          rem_r, rem_nxt;
  logic [DvsW-1:0]          dvs_r;
  logic [$clog2(DivW)-1:0]  cnt_r;
  logic                     busy_r, done_r;
  logic [DvsW:0]            trial;

  always_comb begin
    trial = {rem_r, quo_r[DivW-1]};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = DvsW'(trial - {1'b0, dvs_r});
      quo_nxt = {quo_r[DivW-2:0], 1'b1};
    end else begin
      rem_nxt = trial[DvsW-1:0];
      quo_nxt = {quo_r[DivW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ($clog2(DivW))'(DivW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ rtl/encoder_angle_velocity_tracker_core.sv @@
// encoder tracker top: per-motor state in a 3-entry memory, one transaction at a time
// a bad motor index goes straight to the output; a reading with no velocity estimate
//   is written back; a first estimate takes one divide, a filtered estimate two
// a new reading is taken only once the previous result is in the output register
// reset: synchronous active-low; config to defaults, per-motor valid bits cleared at once
// depends on evav_pkg, evav_if, evav_div and the macros header
`include "encoder_angle_velocity_tracker_core_macros.svh"
module encoder_angle_velocity_tracker_core import evav_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  evav_in_if.sink           in_ch,
  evav_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [23:0]       cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CALC = 4'd1;
  localparam logic [3:0] S_MLO  = 4'd2;
  localparam logic [3:0] S_MHI  = 4'd3;
  localparam logic [3:0] S_D1GO = 4'd4;
  localparam logic [3:0] S_D1W  = 4'd5;
  localparam logic [3:0] S_FMUL = 4'd6;
  localparam logic [3:0] S_D2GO = 4'd7;
  localparam logic [3:0] S_D2W  = 4'd8;
  localparam logic [3:0] S_WB   = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  // config
  logic [MotorCount-1:0]  dir_r;
  logic [AngleBits-1:0]   zo_r [MotorCount];
  logic [5:0]             pp_r;
  logic [19:0]            tf_r, win_r;
  logic [23:0]            to_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= '0;
      for (int i = 0; i < MotorCount; i++) zo_r[i] <= '0;
      pp_r  <= 6'd7;
      tf_r  <= 20'd8000;
      win_r <= 20'd5000;
      to_r  <= 24'd200000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIR: dir_r    <= cfg_data[MotorCount-1:0];
        CFG_ZO0: zo_r[0]  <= cfg_data[AngleBits-1:0];
        CFG_ZO1: zo_r[1]  <= cfg_data[AngleBits-1:0];
        CFG_ZO2: zo_r[2]  <= cfg_data[AngleBits-1:0];
        CFG_PP:  pp_r     <= cfg_data[5:0];
        CFG_TF:  tf_r     <= cfg_data[19:0];
        CFG_WIN: win_r    <= cfg_data[19:0];
        CFG_TO:  to_r     <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // state memory
  st_t                    mem [MotorCount];
  st_t                    rd_r;
  st_t                    nst_r;
  logic                   rd_vld_r;
  logic [MotorCount-1:0]  vld_r;
  logic                   in_acc, rd_en, wr_en;

  logic [3:0]             st_r;
  logic [MotorIdxW-1:0]   m_r;
  logic [AngleBits-1:0]   raw_r;
  logic [31:0]            t_r;
  logic                   ok_r;

  assign in_ch.ready = (st_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign rd_en       = in_acc && (in_ch.motor_index < MotorIdxW'(MotorCount));
  assign wr_en       = (st_r == S_WB);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r <= mem[in_ch.motor_index];
    end
    if (wr_en) begin
      mem[m_r] <= nst_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (rd_en) rd_vld_r <= vld_r[in_ch.motor_index];
      if (wr_en) vld_r[m_r] <= 1'b1;
    end
  end

  // working registers
  logic [23:0]            dt_r;
  logic [AngleBits-1:0]   mag_r;
  logic                   neg_r, upd_r;
  logic [37:0]            plo_r;
  logic [37:0]            phi_r;
  logic signed [24:0]     diff_r;
  logic [23:0]            absd_r;
  logic [47:0]            pm_r;

  logic signed [31:0]     res_turn_r;
  logic signed [23:0]     res_vel_r;
  logic [AngleBits-1:0]   res_elec_r;
  logic                   res_upd_r;

  logic                   out_valid_r;
  logic                   out_load;

  assign out_load = (st_r == S_OUT) && (!out_valid_r || out_ch.ready);

  // divider
  logic                   div_start, div_busy, div_done;
  logic [DivW-1:0]        div_a, div_q;
  logic [DvsW-1:0]        div_b;
  logic [60:0]            num;

  assign div_start = (st_r == S_D1GO) || (st_r == S_D2GO);
  assign num       = {phi_r[36:0], 24'b0} + {23'b0, plo_r};

  always_comb begin
    if (st_r == S_D1GO) begin
      div_a = {10'b0, num[59:22]};
      div_b = {1'b0, dt_r};
    end else begin
      div_a = pm_r;
      div_b = {5'b0, tf_r} + {1'b0, dt_r};
    end
  end

  evav_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // update step
  st_t                    cur;
  st_t                    calc_nst;
  logic                   calc_upd;
  logic signed [AngleBits:0] dturn, dvel;
  logic signed [32:0]     tsum;
  logic [31:0]            dt_full;
  logic [19:0]            win_eff;
  logic [22:0]            qc;
  logic signed [24:0]     xv, yv, dv25;

  always_comb begin
    cur     = rd_vld_r ? rd_r : '0;
    dturn   = wrap_diff(raw_r, cur.last_angle);
    dvel    = wrap_diff(raw_r, cur.ref_angle);
    tsum    = 33'(cur.turn_count) + 33'(dturn);
    dt_full = t_r - cur.ref_time;
    win_eff = (win_r == '0) ? 20'd1 : win_r;
    qc      = (div_q > 48'(VelLim)) ? VelLim : div_q[22:0];
    xv      = neg_r ? -$signed({2'b0, qc}) : $signed({2'b0, qc});
    yv      = 25'(nst_r.velocity);
    dv25    = xv - yv;
    calc_nst = cur;
    calc_upd = 1'b0;
    if (ok_r) begin
      if (!cur.seeded) begin
        calc_nst.seeded     = 1'b1;
        calc_nst.last_angle = raw_r;
        calc_nst.ref_angle  = raw_r;
        calc_nst.ref_time   = t_r;
        calc_nst.turn_count = 32'(raw_r);
        calc_nst.velocity   = '0;
      end else begin
        calc_nst.last_angle = raw_r;
        if (tsum > 33'sh0_7FFF_FFFF) begin
          calc_nst.turn_count = 32'sh7FFF_FFFF;
        end else if (tsum < -33'sh0_8000_0000) begin
          calc_nst.turn_count = 32'sh8000_0000;
        end else begin
          calc_nst.turn_count = tsum[31:0];
        end
        if (dt_full >= 32'(to_r) || dt_full >= 32'(win_eff)) begin
          calc_nst.ref_angle = raw_r;
          calc_nst.ref_time  = t_r;
        end
        if (dt_full < 32'(to_r) && dt_full >= 32'(win_eff)) begin
          calc_upd = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_load || (out_valid_r && !out_ch.ready);
      unique case (st_r)
        S_IDLE: begin
          if (in_acc) st_r <= S_CALC;
        end
        S_CALC: begin
          if (m_r >= MotorIdxW'(MotorCount)) begin
            st_r <= S_OUT;
          end else if (ok_r && cur.seeded &&
                       dt_full < 32'(to_r) && dt_full >= 32'(win_eff)) begin
            st_r <= S_MLO;
          end else begin
            st_r <= S_WB;
          end
        end
        S_MLO:  st_r <= S_MHI;
        S_MHI:  st_r <= S_D1GO;
        S_D1GO: st_r <= S_D1W;
        S_D1W: begin
          if (div_done) st_r <= nst_r.primed ? S_FMUL : S_WB;
        end
        S_FMUL: st_r <= S_D2GO;
        S_D2GO: st_r <= S_D2W;
        S_D2W: begin
          if (div_done) st_r <= S_WB;
        end
        S_WB:   st_r <= S_OUT;
        S_OUT: begin
          if (out_load) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      m_r   <= in_ch.motor_index;
      raw_r <= in_ch.raw_angle;
      t_r   <= in_ch.sample_time_us;
      ok_r  <= in_ch.read_ok;
    end
    unique case (st_r)
      S_CALC: begin
        nst_r <= calc_nst;
        upd_r <= calc_upd;
        dt_r  <= dt_full[23:0];
        mag_r <= dvel[AngleBits] ? AngleBits'(-dvel) : dvel[AngleBits-1:0];
        neg_r <= dir_r[m_r] ^ dvel[AngleBits];
        if (m_r >= MotorIdxW'(MotorCount)) begin
          res_turn_r <= '0;
          res_vel_r  <= '0;
          res_elec_r <= '0;
          res_upd_r  <= 1'b0;
        end
      end
      S_MLO:  plo_r <= mag_r * VelKLo;
      S_MHI:  phi_r <= mag_r * VelKHi;
      S_D1W: begin
        if (div_done) begin
          if (!nst_r.primed) begin
            nst_r.velocity <= xv[23:0];
            nst_r.primed   <= 1'b1;
          end else begin
            diff_r <= dv25;
            absd_r <= dv25[24] ? 24'(-dv25) : dv25[23:0];
          end
        end
      end
      S_FMUL: pm_r <= absd_r * dt_r;
      S_D2W: begin
        if (div_done) begin
          nst_r.velocity <= diff_r[24] ? nst_r.velocity - $signed(div_q[23:0])
                                       : nst_r.velocity + $signed(div_q[23:0]);
        end
      end
      S_WB: begin
        res_turn_r <= nst_r.turn_count;
        res_vel_r  <= nst_r.velocity;
        res_elec_r <= elec_angle(nst_r.last_angle, pp_r, dir_r[m_r], zo_r[m_r]);
        res_upd_r  <= upd_r;
      end
      default: ;
    endcase
  end

  // output register
  logic signed [31:0]     o_turn_r;
  logic signed [23:0]     o_vel_r;
  logic [AngleBits-1:0]   o_elec_r;
  logic                   o_upd_r;

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_turn_r <= res_turn_r;
      o_vel_r  <= res_vel_r;
      o_elec_r <= res_elec_r;
      o_upd_r  <= res_upd_r;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.multi_turn_count  = o_turn_r;
  assign out_ch.filtered_velocity = o_vel_r;
  assign out_ch.elec_phase        = o_elec_r;
  assign out_ch.velocity_updated  = o_upd_r;

  `EVAV_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ch.ready, st_r == S_IDLE)
  `EVAV_ASSERT_NXT(a_div_go, clk, rst_n, div_start, div_busy)
  `EVAV_ASSERT_NXT(a_bad_idx, clk, rst_n,
    (st_r == S_CALC) && (m_r >= MotorIdxW'(MotorCount)), st_r == S_OUT)
  `EVAV_ASSERT_IMP(a_wait_div, clk, rst_n,
    (st_r == S_D1W) || (st_r == S_D2W), div_busy || div_done)

endmodule
